// File: rtl/clpm_pkg.sv
`default_nettype none
package clpm_pkg;

	localparam int NODE_COUNT = 256;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int VALUE_W    = 16;
	localparam int CNT_W      = IDX_W + 1;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_FREE   = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef struct packed {
		logic   rd_en;
		idx_t   rd_addr;
		logic   nx_we;
		idx_t   nx_addr;
		idx_t   nx_data;
		logic   pv_we;
		idx_t   pv_addr;
		idx_t   pv_data;
		logic   pl_we;
		idx_t   pl_addr;
		value_t pl_data;
		logic   us_we;
		idx_t   us_addr;
		logic   us_data;
	} store_req_t;

	typedef struct packed {
		idx_t   nx;
		idx_t   pv;
		value_t pl;
		logic   used;
	} store_rsp_t;

endpackage
`default_nettype wire

// File: rtl/circular_list_pool_manager.sv
// Channel   Handshake             Payload
// command   in_valid / in_ready   kind, target_valid, target_index, item_value
// result    out_valid / out_ready status, result_valid, result_index, read_value,
//                                 read_used
//
// One command at a time; in_ready is high only while the sequencer idles.
// Read and remove first read the target node, and remove then unlinks it; with an empty
// target both go straight to the result. Free walks the list from the target, clearing
// used flags until back at the target or after 256 nodes. Insert scans the used flags
// from the cursor and links a free node before the target; a full pool sets status.
// Reset clears all used flags and the allocation cursor at once; no clearing pass.
// A result waiting in the output register holds the next command only at its end.
`default_nettype none
module circular_list_pool_manager (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            kind,
	input  wire logic                  target_valid,
	input  wire logic [7:0]            target_index,
	input  wire logic [15:0]           item_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       status,
	output logic                       result_valid,
	output logic [7:0]                 result_index,
	output logic [15:0]                read_value,
	output logic                       read_used
);

	clpm_pkg::store_req_t store_req;
	clpm_pkg::store_rsp_t store_rsp;

	clpm_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.target_valid (target_valid),
		.target_index (target_index),
		.item_value   (item_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_valid (result_valid),
		.result_index (result_index),
		.read_value   (read_value),
		.read_used    (read_used),
		.store_req    (store_req),
		.store_rsp    (store_rsp)
	);

	clpm_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rsp    (store_rsp)
	);

endmodule
`default_nettype wire

// File: rtl/clpm_store.sv
`default_nettype none
module clpm_store (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire clpm_pkg::store_req_t  req,
	output clpm_pkg::store_rsp_t       rsp
);

	clpm_pkg::idx_t   nx_mem [clpm_pkg::NODE_COUNT];
	clpm_pkg::idx_t   pv_mem [clpm_pkg::NODE_COUNT];
	clpm_pkg::value_t pl_mem [clpm_pkg::NODE_COUNT];
	logic [clpm_pkg::NODE_COUNT-1:0] used_q;

	always_ff @(posedge clk) begin
		if (req.nx_we) begin
			nx_mem[req.nx_addr] <= req.nx_data;
		end
		if (req.pv_we) begin
			pv_mem[req.pv_addr] <= req.pv_data;
		end
		if (req.pl_we) begin
			pl_mem[req.pl_addr] <= req.pl_data;
		end
		if (req.rd_en) begin
			rsp.nx   <= nx_mem[req.rd_addr];
			rsp.pv   <= pv_mem[req.rd_addr];
			rsp.pl   <= pl_mem[req.rd_addr];
			rsp.used <= used_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (req.us_we) begin
			used_q[req.us_addr] <= req.us_data;
		end
	end

endmodule
`default_nettype wire

// File: rtl/clpm_seq.sv
`default_nettype none
module clpm_seq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            kind,
	input  wire logic                  target_valid,
	input  wire clpm_pkg::idx_t        target_index,
	input  wire clpm_pkg::value_t      item_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       status,
	output logic                       result_valid,
	output clpm_pkg::idx_t             result_index,
	output clpm_pkg::value_t           read_value,
	output logic                       read_used,
	output clpm_pkg::store_req_t       store_req,
	input  wire clpm_pkg::store_rsp_t  store_rsp
);

	typedef enum logic [12:0] {
		ST_IDLE    = 13'b0000000000001,
		ST_SCAN_RD = 13'b0000000000010,
		ST_SCAN_CK = 13'b0000000000100,
		ST_INS_RD  = 13'b0000000001000,
		ST_INS_LA  = 13'b0000000010000,
		ST_INS_LB  = 13'b0000000100000,
		ST_RM_RD   = 13'b0000001000000,
		ST_RM_WR   = 13'b0000010000000,
		ST_FR_RD   = 13'b0000100000000,
		ST_FR_WK   = 13'b0001000000000,
		ST_RD_RD   = 13'b0010000000000,
		ST_RD_WR   = 13'b0100000000000,
		ST_DONE    = 13'b1000000000000
	} state_t;

	state_t             state_q, state_d;
	clpm_pkg::idx_t     cur_q, cur_d;
	clpm_pkg::cnt_t     cnt_q, cnt_d;
	logic               out_valid_q, out_valid_d;
	logic               out_load;
	logic               tv_q;
	clpm_pkg::idx_t     tidx_q;
	clpm_pkg::value_t   val_q;
	clpm_pkg::idx_t     node_q, node_d;
	logic               res_status_q, res_status_d;
	logic               res_valid_q, res_valid_d;
	clpm_pkg::idx_t     res_idx_q, res_idx_d;
	clpm_pkg::value_t   res_value_q, res_value_d;
	logic               res_used_q, res_used_d;
	logic               out_status_q, out_rvalid_q, out_used_q;
	clpm_pkg::idx_t     out_idx_q;
	clpm_pkg::value_t   out_value_q;
	logic               eq_w;
	clpm_pkg::cnt_t     cnt_inc;
	clpm_pkg::idx_t     link_w;
	logic               accept;

	assign in_ready     = (state_q == ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign eq_w         = (store_rsp.nx == tidx_q);
	assign cnt_inc      = cnt_q + clpm_pkg::cnt_t'(1);
	assign link_w       = tv_q ? store_rsp.pv : node_q;
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign result_valid = out_rvalid_q;
	assign result_index = out_idx_q;
	assign read_value   = out_value_q;
	assign read_used    = out_used_q;

	always_comb begin
		state_d      = state_q;
		cur_d        = cur_q;
		cnt_d        = cnt_q;
		node_d       = node_q;
		res_status_d = res_status_q;
		res_valid_d  = res_valid_q;
		res_idx_d    = res_idx_q;
		res_value_d  = res_value_q;
		res_used_d   = res_used_q;
		out_load     = 1'b0;
		store_req    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_status_d = 1'b0;
					res_valid_d  = 1'b0;
					res_idx_d    = '0;
					res_value_d  = '0;
					res_used_d   = 1'b0;
					cnt_d        = '0;
					node_d       = target_index;
					unique case (clpm_pkg::kind_t'(kind))
						clpm_pkg::KIND_INSERT: state_d = ST_SCAN_RD;
						clpm_pkg::KIND_REMOVE: state_d = target_valid ? ST_RM_RD : ST_DONE;
						clpm_pkg::KIND_FREE:   state_d = target_valid ? ST_FR_RD : ST_DONE;
						clpm_pkg::KIND_READ:   state_d = target_valid ? ST_RD_RD : ST_DONE;
						default:               state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN_RD: begin
				store_req.rd_en   = 1'b1;
				store_req.rd_addr = cur_q;
				state_d           = ST_SCAN_CK;
			end
			ST_SCAN_CK: begin
				if (!store_rsp.used) begin
					node_d  = cur_q;
					state_d = tv_q ? ST_INS_RD : ST_INS_LA;
				end else begin
					cur_d = cur_q + clpm_pkg::idx_t'(1);
					cnt_d = cnt_inc;
					if (cnt_inc[clpm_pkg::IDX_W]) begin
						res_status_d = 1'b1;
						state_d      = ST_DONE;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_INS_RD: begin
				store_req.rd_en   = 1'b1;
				store_req.rd_addr = tidx_q;
				state_d           = ST_INS_LA;
			end
			ST_INS_LA: begin
				store_req.nx_we   = 1'b1;
				store_req.nx_addr = link_w;
				store_req.nx_data = node_q;
				store_req.pv_we   = 1'b1;
				store_req.pv_addr = node_q;
				store_req.pv_data = link_w;
				store_req.pl_we   = 1'b1;
				store_req.pl_addr = node_q;
				store_req.pl_data = val_q;
				store_req.us_we   = 1'b1;
				store_req.us_addr = node_q;
				store_req.us_data = 1'b1;
				res_valid_d       = 1'b1;
				res_idx_d         = node_q;
				state_d           = tv_q ? ST_INS_LB : ST_DONE;
			end
			ST_INS_LB: begin
				store_req.nx_we   = 1'b1;
				store_req.nx_addr = node_q;
				store_req.nx_data = tidx_q;
				store_req.pv_we   = 1'b1;
				store_req.pv_addr = tidx_q;
				store_req.pv_data = node_q;
				state_d           = ST_DONE;
			end
			ST_RM_RD: begin
				store_req.rd_en   = 1'b1;
				store_req.rd_addr = tidx_q;
				state_d           = ST_RM_WR;
			end
			ST_RM_WR: begin
				store_req.us_we   = 1'b1;
				store_req.us_addr = tidx_q;
				store_req.us_data = 1'b0;
				if (!eq_w) begin
					store_req.nx_we   = 1'b1;
					store_req.nx_addr = store_rsp.pv;
					store_req.nx_data = store_rsp.nx;
					store_req.pv_we   = 1'b1;
					store_req.pv_addr = store_rsp.nx;
					store_req.pv_data = store_rsp.pv;
					res_valid_d       = 1'b1;
					res_idx_d         = store_rsp.nx;
				end
				state_d = ST_DONE;
			end
			ST_FR_RD: begin
				store_req.rd_en   = 1'b1;
				store_req.rd_addr = node_q;
				state_d           = ST_FR_WK;
			end
			ST_FR_WK: begin
				store_req.us_we   = 1'b1;
				store_req.us_addr = node_q;
				store_req.us_data = 1'b0;
				node_d            = store_rsp.nx;
				cnt_d             = cnt_inc;
				state_d           = (eq_w || cnt_inc[clpm_pkg::IDX_W]) ? ST_DONE : ST_FR_RD;
			end
			ST_RD_RD: begin
				store_req.rd_en   = 1'b1;
				store_req.rd_addr = tidx_q;
				state_d           = ST_RD_WR;
			end
			ST_RD_WR: begin
				res_valid_d = 1'b1;
				res_idx_d   = store_rsp.nx;
				res_value_d = store_rsp.pl;
				res_used_d  = store_rsp.used;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_q       <= cur_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tv_q   <= target_valid;
			tidx_q <= target_index;
			val_q  <= item_value;
		end
		node_q       <= node_d;
		res_status_q <= res_status_d;
		res_valid_q  <= res_valid_d;
		res_idx_q    <= res_idx_d;
		res_value_q  <= res_value_d;
		res_used_q   <= res_used_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_rvalid_q <= res_valid_q;
			out_idx_q    <= res_idx_q;
			out_value_q  <= res_value_q;
			out_used_q   <= res_used_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/clpm_checker.sv
`default_nettype none
module clpm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  kind,
	input wire logic        target_valid,
	input wire logic [7:0]  target_index,
	input wire logic [15:0] item_value,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        status,
	input wire logic        result_valid,
	input wire logic [7:0]  result_index,
	input wire logic [15:0] read_value,
	input wire logic        read_used
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(target_valid)
			&& $stable(target_index) && $stable(item_value))
		else $error("command dropped or changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_valid)
			&& $stable(result_index) && $stable(read_value) && $stable(read_used))
		else $error("result dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while busy");

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_valid |-> result_index == 8'd0 && !read_used)
		else $error("empty result carries an index or used flag");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !result_valid && read_value == 16'd0)
		else $error("pool full result names a node");

endmodule

bind circular_list_pool_manager clpm_checker u_clpm_checker (.*);
`default_nettype wire

// File: sim/circular_list_pool_manager_tb.sv
`default_nettype none
module circular_list_pool_manager_tb;

	localparam int WATCHDOG_LIMIT = 8000;
	localparam int DRAIN_CYCLES   = 600;
	localparam int RAND_PER_PHASE = 480;
	localparam int RX_HOLD_AT     = 200;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int REPORT_LINES   = 40;
	localparam int DIR_ROWS       = 20;

	localparam int GEN_MIX   = 0;
	localparam int GEN_FILL  = 1;
	localparam int GEN_DRAIN = 2;

	localparam clpm_pkg::kind_t K_INS = clpm_pkg::KIND_INSERT;
	localparam clpm_pkg::kind_t K_RM  = clpm_pkg::KIND_REMOVE;
	localparam clpm_pkg::kind_t K_FR  = clpm_pkg::KIND_FREE;
	localparam clpm_pkg::kind_t K_RD  = clpm_pkg::KIND_READ;

	typedef struct packed {
		clpm_pkg::kind_t  kind;
		logic             tvalid;
		clpm_pkg::idx_t   tidx;
		clpm_pkg::value_t value;
	} cmd_t;

	typedef struct packed {
		logic             status;
		logic             rvalid;
		clpm_pkg::idx_t   ridx;
		clpm_pkg::value_t rvalue;
		logic             rused;
	} res_t;

	typedef struct {
		cmd_t cmd;
		bit   typed;
		res_t want;
	} dir_row_t;

	localparam res_t RES_NONE = '{default: '0};

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_ready;
	logic [1:0]   kind;
	logic         target_valid;
	logic [7:0]   target_index;
	logic [15:0]  item_value;
	logic         out_valid;
	logic         out_ready;
	logic         status;
	logic         result_valid;
	logic [7:0]   result_index;
	logic [15:0]  read_value;
	logic         read_used;

	bit               pool_used    [clpm_pkg::NODE_COUNT];
	bit               pool_written [clpm_pkg::NODE_COUNT];
	clpm_pkg::value_t pool_value   [clpm_pkg::NODE_COUNT];
	clpm_pkg::idx_t   pool_prev    [clpm_pkg::NODE_COUNT];
	clpm_pkg::idx_t   pool_next    [clpm_pkg::NODE_COUNT];
	int               pool_cursor = 0;

	res_t   pending_results [$];
	res_t   oldest;
	int     mismatch_count = 0;
	int     results_seen = 0;
	int     kind_seen [4] = '{default: 0};
	int     full_count = 0;
	int     solo_removes = 0;
	int     tx_idle_pct = 10;
	int     rx_idle_pct = 68;
	bit     rx_hold_done = 0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{K_INS, 1'b0, 8'hFF, 16'hFFFF}, 1'b1, '{1'b0, 1'b1, 8'h00, 16'h0000, 1'b0}},
		'{'{K_INS, 1'b1, 8'h00, 16'h0000}, 1'b1, '{1'b0, 1'b1, 8'h01, 16'h0000, 1'b0}},
		'{'{K_INS, 1'b1, 8'h00, 16'hA5A5}, 1'b1, '{1'b0, 1'b1, 8'h02, 16'h0000, 1'b0}},
		'{'{K_RD,  1'b1, 8'h00, 16'h0000}, 1'b1, '{1'b0, 1'b1, 8'h01, 16'hFFFF, 1'b1}},
		'{'{K_RD,  1'b1, 8'h02, 16'h5A5A}, 1'b1, '{1'b0, 1'b1, 8'h00, 16'hA5A5, 1'b1}},
		'{'{K_RM,  1'b0, 8'hFF, 16'h0000}, 1'b1, RES_NONE},
		'{'{K_RM,  1'b1, 8'h01, 16'hFFFF}, 1'b1, '{1'b0, 1'b1, 8'h02, 16'h0000, 1'b0}},
		'{'{K_RD,  1'b1, 8'h01, 16'h0000}, 1'b1, '{1'b0, 1'b1, 8'h02, 16'h0000, 1'b0}},
		'{'{K_FR,  1'b1, 8'h01, 16'h0000}, 1'b1, RES_NONE},
		'{'{K_RD,  1'b1, 8'h00, 16'h0000}, 1'b0, RES_NONE},
		'{'{K_INS, 1'b0, 8'h00, 16'h1234}, 1'b0, RES_NONE},
		'{'{K_RM,  1'b1, 8'h02, 16'h0000}, 1'b1, RES_NONE},
		'{'{K_INS, 1'b1, 8'h00, 16'h0F0F}, 1'b0, RES_NONE},
		'{'{K_INS, 1'b1, 8'h00, 16'hF0F0}, 1'b0, RES_NONE},
		'{'{K_FR,  1'b0, 8'hAA, 16'h0000}, 1'b1, RES_NONE},
		'{'{K_RD,  1'b0, 8'h55, 16'h0000}, 1'b1, RES_NONE},
		'{'{K_FR,  1'b1, 8'h00, 16'h0000}, 1'b1, RES_NONE},
		'{'{K_RD,  1'b1, 8'h00, 16'h0000}, 1'b0, RES_NONE},
		'{'{K_INS, 1'b0, 8'h00, 16'h8000}, 1'b0, RES_NONE},
		'{'{K_RD,  1'b1, 8'h01, 16'hFFFF}, 1'b0, RES_NONE}
	};

	circular_list_pool_manager u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.target_valid (target_valid),
		.target_index (target_index),
		.item_value   (item_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_valid (result_valid),
		.result_index (result_index),
		.read_value   (read_value),
		.read_used    (read_used)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic res_t apply_pool_cmd(cmd_t c);
		res_t r;
		int   t;
		int   n;
		int   p;
		int   nx;
		int   cur;
		int   steps;
		bit   found;
		r = RES_NONE;
		t = int'(c.tidx);
		kind_seen[c.kind]++;
		if (c.tvalid && t >= clpm_pkg::NODE_COUNT) begin
			return r;
		end
		unique case (c.kind)
			K_INS: begin
				found = 1'b0;
				for (steps = 0; steps < clpm_pkg::NODE_COUNT && !found; steps++) begin
					if (!pool_used[pool_cursor]) begin
						found = 1'b1;
					end else begin
						pool_cursor = (pool_cursor + 1) % clpm_pkg::NODE_COUNT;
					end
				end
				if (!found) begin
					r.status = 1'b1;
					full_count++;
				end else begin
					n = pool_cursor;
					if (!c.tvalid) begin
						pool_prev[n] = clpm_pkg::idx_t'(n);
						pool_next[n] = clpm_pkg::idx_t'(n);
					end else begin
						p = int'(pool_prev[t]);
						pool_next[p] = clpm_pkg::idx_t'(n);
						pool_prev[n] = clpm_pkg::idx_t'(p);
						pool_next[n] = clpm_pkg::idx_t'(t);
						pool_prev[t] = clpm_pkg::idx_t'(n);
					end
					pool_value[n]   = c.value;
					pool_used[n]    = 1'b1;
					pool_written[n] = 1'b1;
					r.rvalid = 1'b1;
					r.ridx   = clpm_pkg::idx_t'(n);
				end
			end
			K_RM: begin
				if (c.tvalid) begin
					pool_used[t] = 1'b0;
					if (int'(pool_next[t]) != t) begin
						p  = int'(pool_prev[t]);
						nx = int'(pool_next[t]);
						pool_next[p]  = clpm_pkg::idx_t'(nx);
						pool_prev[nx] = clpm_pkg::idx_t'(p);
						r.rvalid = 1'b1;
						r.ridx   = clpm_pkg::idx_t'(nx);
					end else begin
						solo_removes++;
					end
				end
			end
			K_FR: begin
				if (c.tvalid) begin
					cur   = t;
					steps = 0;
					do begin
						pool_used[cur] = 1'b0;
						cur = int'(pool_next[cur]);
						steps++;
					end while (cur != t && steps < clpm_pkg::NODE_COUNT);
				end
			end
			K_RD: begin
				if (c.tvalid) begin
					r.rvalid = 1'b1;
					r.ridx   = pool_next[t];
					r.rvalue = pool_value[t];
					r.rused  = pool_used[t];
				end
			end
		endcase
		return r;
	endfunction

	function automatic int live_count();
		int cnt;
		cnt = 0;
		foreach (pool_used[i]) begin
			if (pool_used[i]) cnt++;
		end
		return cnt;
	endfunction

	function automatic cmd_t pick_cmd(int mode);
		cmd_t           c;
		clpm_pkg::idx_t live [$];
		clpm_pkg::idx_t known [$];
		int             r;
		foreach (pool_used[i]) begin
			if (pool_used[i]) live.push_back(clpm_pkg::idx_t'(i));
			if (pool_written[i]) known.push_back(clpm_pkg::idx_t'(i));
		end
		c.kind   = K_INS;
		c.tvalid = 1'b0;
		c.tidx   = clpm_pkg::idx_t'($urandom);
		c.value  = clpm_pkg::value_t'($urandom);
		r = $urandom_range(99);
		if (mode == GEN_DRAIN) begin
			if (r < 60) c.kind = K_FR;
			else if (r < 85) c.kind = K_RM;
			else c.kind = K_RD;
		end else if (mode == GEN_MIX) begin
			if (r < 40) c.kind = K_INS;
			else if (r < 62) c.kind = K_RM;
			else if (r < 72) c.kind = K_FR;
			else c.kind = K_RD;
		end
		if (mode == GEN_MIX && $urandom_range(99) < 12) begin
			if (known.size() > 0 && $urandom_range(1) == 1) begin
				c.tvalid = 1'b1;
				c.tidx   = known[$urandom_range(known.size() - 1)];
			end
		end else if (live.size() > 0 &&
				!(c.kind == K_INS && $urandom_range(99) < 20)) begin
			c.tvalid = 1'b1;
			c.tidx   = live[$urandom_range(live.size() - 1)];
		end
		return c;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LINES) begin
			$display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
		end
	endtask

	task automatic issue(cmd_t c, bit typed, res_t want);
		res_t got;
		in_valid     <= 1'b1;
		kind         <= c.kind;
		target_valid <= c.tvalid;
		target_index <= c.tidx;
		item_value   <= c.value;
		do @(posedge clk); while (!in_ready);
		got = apply_pool_cmd(c);
		pending_results.push_back(typed ? want : got);
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_mismatch("transfer with nothing pending", 0, 0);
			end else begin
				oldest = pending_results.pop_front();
				if (status !== oldest.status)
					flag_mismatch("status", status, oldest.status);
				if (result_valid !== oldest.rvalid)
					flag_mismatch("result_valid", result_valid, oldest.rvalid);
				if (result_index !== oldest.ridx)
					flag_mismatch("result_index", result_index, oldest.ridx);
				if (read_value !== oldest.rvalue)
					flag_mismatch("read_value", read_value, oldest.rvalue);
				if (read_used !== oldest.rused)
					flag_mismatch("read_used", read_used, oldest.rused);
			end
		end
	end

	initial begin : result_drain
		int hold;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			@(posedge clk);
			if (!rx_hold_done && results_seen >= RX_HOLD_AT) begin
				rx_hold_done = 1'b1;
				out_ready <= 1'b0;
				for (hold = 0; hold < RX_HOLD_CYCLES; hold++) @(posedge clk);
			end
			out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		cmd_t c;
		int   ph;
		int   n;
		int   row;
		int   mode;
		int   fill_mark;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		kind         <= K_INS;
		target_valid <= 1'b0;
		target_index <= '0;
		item_value   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < DIR_ROWS; row++) begin
			issue(dir_rows[row].cmd, dir_rows[row].typed, dir_rows[row].want);
		end

		mode = GEN_MIX;
		fill_mark = 0;
		for (ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 68 : 0;
			rx_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 10 : 0;
			if (ph > 0) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
				mode = GEN_FILL;
				fill_mark = full_count;
			end
			for (n = 0; n < RAND_PER_PHASE; n++) begin
				if (mode == GEN_FILL && full_count >= fill_mark + 3) mode = GEN_DRAIN;
				else if (mode == GEN_DRAIN && live_count() < 16) mode = GEN_MIX;
				c = pick_cmd(mode);
				issue(c, 1'b0, RES_NONE);
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("results never returned", 0, pending_results.size());

		$display("ran %0d commands: %0d insert, %0d remove, %0d free, %0d read",
			kind_seen[K_INS] + kind_seen[K_RM] + kind_seen[K_FR] + kind_seen[K_RD],
			kind_seen[K_INS], kind_seen[K_RM], kind_seen[K_FR], kind_seen[K_RD]);
		$display("%0d inserts into a full pool, %0d single-node removes, %0d results checked",
			full_count, solo_removes, results_seen);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: circular_list_pool_manager.f
rtl/clpm_pkg.sv
rtl/clpm_store.sv
rtl/clpm_seq.sv
rtl/circular_list_pool_manager.sv
rtl/clpm_checker.sv
sim/circular_list_pool_manager_tb.sv
